@@ design/mck_pkg.sv @@
package mck_pkg;

	localparam int StepW = 3;

	typedef logic [StepW-1:0] step_t;

	// Microprogram addresses
	localparam step_t STEP_IDLE  = 3'd0;
	localparam step_t STEP_DEC   = 3'd1;
	localparam step_t STEP_SYM   = 3'd2;
	localparam step_t STEP_GAP   = 3'd3;
	localparam step_t STEP_LGAP  = 3'd4;
	localparam step_t STEP_SPACE = 3'd5;

	// Sequencing modes of one control word
	typedef enum logic [2:0] {
		SEQ_NEXT,   // advance
		SEQ_JUMP,   // jump to target
		SEQ_WAIT,   // hold until start, then advance
		SEQ_CLASS,  // space: target, unknown: idle, else advance
		SEQ_LOOP    // more symbols: target, else advance
	} seq_mode_t;

	// Unit counts, stored as units minus one
	localparam logic [1:0] UNITS_1 = 2'd0;
	localparam logic [1:0] UNITS_2 = 2'd1;
	localparam logic [1:0] UNITS_3 = 2'd2;
	localparam logic [1:0] UNITS_4 = 2'd3;

	typedef struct packed {
		seq_mode_t  mode;
		step_t      target;
		logic       ld_char;
		logic       ld_sym;
		logic       emit;
		logic       key;
		logic       sym_units; // units follow the current symbol (1 or 3)
		logic [1:0] units;
		logic       last;
		logic       advance;   // drop the current symbol
	} ctrl_t;

	typedef struct packed {
		logic start;
		logic is_space;
		logic is_unknown;
		logic more;
	} status_t;

	// Code table: length in [7:5], pattern in [4:0]; pattern bit (len-1-i) is symbol i
	function automatic logic [7:0] mck_code(input logic [5:0] idx);
		logic [7:0] r;
		case (idx)
			6'd0:  r = {3'd2, 5'h01};
			6'd1:  r = {3'd4, 5'h08};
			6'd2:  r = {3'd4, 5'h0A};
			6'd3:  r = {3'd3, 5'h04};
			6'd4:  r = {3'd1, 5'h00};
			6'd5:  r = {3'd4, 5'h02};
			6'd6:  r = {3'd3, 5'h06};
			6'd7:  r = {3'd4, 5'h00};
			6'd8:  r = {3'd2, 5'h00};
			6'd9:  r = {3'd4, 5'h07};
			6'd10: r = {3'd3, 5'h05};
			6'd11: r = {3'd4, 5'h04};
			6'd12: r = {3'd2, 5'h03};
			6'd13: r = {3'd2, 5'h02};
			6'd14: r = {3'd3, 5'h07};
			6'd15: r = {3'd4, 5'h06};
			6'd16: r = {3'd4, 5'h0D};
			6'd17: r = {3'd3, 5'h02};
			6'd18: r = {3'd3, 5'h00};
			6'd19: r = {3'd1, 5'h01};
			6'd20: r = {3'd3, 5'h01};
			6'd21: r = {3'd4, 5'h01};
			6'd22: r = {3'd3, 5'h03};
			6'd23: r = {3'd4, 5'h09};
			6'd24: r = {3'd4, 5'h0B};
			6'd25: r = {3'd4, 5'h0C};
			6'd26: r = {3'd5, 5'h1F};
			6'd27: r = {3'd5, 5'h0F};
			6'd28: r = {3'd5, 5'h07};
			6'd29: r = {3'd5, 5'h03};
			6'd30: r = {3'd5, 5'h01};
			6'd31: r = {3'd5, 5'h00};
			6'd32: r = {3'd5, 5'h10};
			6'd33: r = {3'd5, 5'h18};
			6'd34: r = {3'd5, 5'h1C};
			6'd35: r = {3'd5, 5'h1E};
			default: r = {3'd1, 5'h00};
		endcase
		return r;
	endfunction

endpackage

@@ design/mck_seq.sv @@
module mck_seq import mck_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl,
	output logic    busy
);

	step_t pc_q;
	step_t pc_next;

	// Control store
	always_comb begin
		ctrl = '0;
		unique case (pc_q)
			STEP_IDLE: begin
				ctrl.mode    = SEQ_WAIT;
				ctrl.ld_char = 1'b1;
			end
			STEP_DEC: begin
				ctrl.mode   = SEQ_CLASS;
				ctrl.target = STEP_SPACE;
				ctrl.ld_sym = 1'b1;
			end
			STEP_SYM: begin
				ctrl.mode      = SEQ_NEXT;
				ctrl.emit      = 1'b1;
				ctrl.key       = 1'b1;
				ctrl.sym_units = 1'b1;
			end
			STEP_GAP: begin
				ctrl.mode    = SEQ_LOOP;
				ctrl.target  = STEP_SYM;
				ctrl.emit    = 1'b1;
				ctrl.units   = UNITS_1;
				ctrl.advance = 1'b1;
			end
			STEP_LGAP: begin
				ctrl.mode   = SEQ_JUMP;
				ctrl.target = STEP_IDLE;
				ctrl.emit   = 1'b1;
				ctrl.units  = UNITS_2;
				ctrl.last   = 1'b1;
			end
			STEP_SPACE: begin
				ctrl.mode   = SEQ_JUMP;
				ctrl.target = STEP_IDLE;
				ctrl.emit   = 1'b1;
				ctrl.units  = UNITS_4;
				ctrl.last   = 1'b1;
			end
			default: begin
				ctrl.mode   = SEQ_JUMP;
				ctrl.target = STEP_IDLE;
			end
		endcase
	end

	// Select the next step
	always_comb begin
		pc_next = pc_q + step_t'(1);
		unique case (ctrl.mode)
			SEQ_NEXT:  pc_next = pc_q + step_t'(1);
			SEQ_JUMP:  pc_next = ctrl.target;
			SEQ_WAIT:  pc_next = status.start ? pc_q + step_t'(1) : pc_q;
			SEQ_CLASS: begin
				if (status.is_space)
					pc_next = ctrl.target;
				else if (status.is_unknown)
					pc_next = STEP_IDLE;
				else
					pc_next = pc_q + step_t'(1);
			end
			SEQ_LOOP:  pc_next = status.more ? ctrl.target : pc_q + step_t'(1);
			default:   pc_next = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= STEP_IDLE;
		else
			pc_q <= pc_next;
	end

	assign busy = (pc_q != STEP_IDLE);

endmodule

@@ design/mck_datapath.sv @@
module mck_datapath import mck_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_t       ctrl,
	input  logic        start,
	input  logic [7:0]  char_code,
	input  logic        tpu_we,
	input  logic [15:0] tpu_wdata,
	output status_t     status,
	output logic        key_on,
	output logic [17:0] duration_ticks,
	output logic        last,
	output logic        strobe
);

	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpZ   = 8'h5A;
	localparam logic [7:0] ChLoA   = 8'h61;
	localparam logic [7:0] ChLoZ   = 8'h7A;
	localparam logic [7:0] Ch0     = 8'h30;
	localparam logic [7:0] Ch9     = 8'h39;

	logic [7:0]  char_q;
	logic [4:0]  pat_q;
	logic [2:0]  cnt_q;
	logic [15:0] tpu_q;

	logic [5:0]  idx;
	logic [7:0]  code;
	logic        unknown;
	logic        dash;
	logic [1:0]  units;
	logic [17:0] dur;
	logic [7:0]  diff;

	// Classify the character and form the table index
	always_comb begin
		unknown = 1'b0;
		diff    = 8'd0;
		idx     = 6'd0;
		if (char_q >= ChUpA && char_q <= ChUpZ) begin
			diff = char_q - ChUpA;
			idx  = diff[5:0];
		end else if (char_q >= ChLoA && char_q <= ChLoZ) begin
			diff = char_q - ChLoA;
			idx  = diff[5:0];
		end else if (char_q >= Ch0 && char_q <= Ch9) begin
			diff = char_q - Ch0 + 8'd26;
			idx  = diff[5:0];
		end else begin
			unknown = 1'b1;
		end
	end

	assign code = mck_code(idx);

	assign status.start      = start;
	assign status.is_space   = (char_q == ChSpace);
	assign status.is_unknown = unknown;
	assign status.more       = (cnt_q > 3'd1);

	// Current symbol sits at bit cnt-1 of the pattern
	assign dash  = pat_q[3'(cnt_q - 3'd1)];
	assign units = ctrl.sym_units ? (dash ? UNITS_3 : UNITS_1) : ctrl.units;

	// Units times ticks per unit, by shift and add
	always_comb begin
		case (units)
			UNITS_1: dur = {2'b00, tpu_q};
			UNITS_2: dur = {1'b0, tpu_q, 1'b0};
			UNITS_3: dur = {2'b00, tpu_q} + {1'b0, tpu_q, 1'b0};
			default: dur = {tpu_q, 2'b00};
		endcase
	end

	// Hold the character and its symbols
	always_ff @(posedge clk) begin
		if (ctrl.ld_char)
			char_q <= char_code;
		if (ctrl.ld_sym) begin
			pat_q <= code[4:0];
			cnt_q <= code[7:5];
		end else if (ctrl.advance) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// Unit length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tpu_q <= 16'd250;
		else if (tpu_we)
			tpu_q <= tpu_wdata;
	end

	// Result register: one beat per emit step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe <= 1'b0;
		else
			strobe <= ctrl.emit;
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			key_on         <= ctrl.key;
			duration_ticks <= dur;
			last           <= ctrl.last;
		end
	end

endmodule

@@ design/morse_code_keyer_unit.sv @@
// Channel   | Signals                              | Beat taken when
// ----------+--------------------------------------+--------------------------
// command   | start, busy, char_code               | start && !busy
// config    | cfg_valid, cfg_ready, cfg_data       | cfg_valid && cfg_ready
// result    | strobe, key_on, duration_ticks, last | strobe (one cycle each)
//
// A letter or digit of n symbols yields 2n + 1 result beats, a space one
// beat, an unknown character none; one step of the microprogram runs
// per cycle and each emit step yields one result beat.
// The next start is taken in the cycle the final beat is shown.
// Reset sets the unit length to 250 ticks and returns the sequencer to idle.
// Results cannot be stalled; config is taken whenever the unit is not busy.
module morse_code_keyer_unit import mck_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  char_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        strobe,
	output logic        key_on,
	output logic [17:0] duration_ticks,
	output logic        last
);

	ctrl_t   ctrl;
	status_t status;

	mck_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	assign cfg_ready = !busy;

	mck_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.start          (start),
		.char_code      (char_code),
		.tpu_we         (cfg_valid && cfg_ready),
		.tpu_wdata      (cfg_data),
		.status         (status),
		.key_on         (key_on),
		.duration_ticks (duration_ticks),
		.last           (last),
		.strobe         (strobe)
	);

	// Final beat of a character leaves the sequencer idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("final beat while sequencer busy");

	// An accepted command starts the program
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command accepted but sequencer idle");

	// Every key-on segment is followed at once by an off gap
	a_sym_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && key_on |=> strobe && !key_on && !last)
		else $error("symbol not followed by gap");

	// Beats come only from a running program
	a_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("beat without running program");

endmodule

@@ tb/tb_top.sv @@
module tb_top;

	localparam int CLK_PERIOD = 12;
	localparam int SETTLE_CYCLES = 4;
	localparam int LIMIT_CYCLES = 400000;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [15:0] UNIT_RESET = 16'd250;
	localparam int RANDOM_CHARS = 340;

	typedef struct packed {
		logic        key;
		logic [17:0] dur;
		logic        last;
	} segment_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [7:0]  char_code = 8'h00;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;
	logic        strobe;
	logic        key_on;
	logic [17:0] duration_ticks;
	logic        last;

	// Dots and dashes of A..Z then 0..9
	string morse_tbl [36] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-",
		".....", "-....", "--...", "---..", "----."
	};

	logic [15:0] unit_ticks = UNIT_RESET;
	segment_t    pending_segs [$];
	int          failures = 0;
	int          segs_checked = 0;
	int          chars_sent = 0;
	int          chars_silent = 0;
	int          unit_writes = 0;
	logic [17:0] longest_seg = '0;

	morse_code_keyer_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.char_code      (char_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.strobe         (strobe),
		.key_on         (key_on),
		.duration_ticks (duration_ticks),
		.last           (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Queue one expected segment of the given length in units
	function automatic void expect_seg(input logic key, input int units, input logic fin);
		segment_t    seg;
		logic [31:0] prod;
		prod = units * unit_ticks;
		seg.key = key;
		seg.dur = prod[17:0];
		seg.last = fin;
		pending_segs.push_back(seg);
	endfunction

	// Expand one character into its keying segments; returns how many
	function automatic int key_char_segments(input logic [7:0] c);
		int    idx;
		string sym;
		if (c == CH_SPACE) begin
			expect_seg(1'b0, 4, 1'b1);
			return 1;
		end
		if (c >= "A" && c <= "Z")
			idx = c - "A";
		else if (c >= "a" && c <= "z")
			idx = c - "a";
		else if (c >= "0" && c <= "9")
			idx = 26 + (c - "0");
		else
			return 0;
		sym = morse_tbl[idx];
		for (int i = 0; i < sym.len(); i++) begin
			expect_seg(1'b1, (sym[i] == "-") ? 3 : 1, 1'b0);
			expect_seg(1'b0, 1, 1'b0);
		end
		expect_seg(1'b0, 2, 1'b1);
		return 2 * sym.len() + 1;
	endfunction

	// Mostly back to back, sometimes short gaps, rarely long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99, 0);
		if (r < 35)
			return 8'("A" + $urandom_range(25, 0));
		if (r < 55)
			return 8'("a" + $urandom_range(25, 0));
		if (r < 75)
			return 8'("0" + $urandom_range(9, 0));
		if (r < 85)
			return CH_SPACE;
		return 8'($urandom_range(255, 0));
	endfunction

	// Send one character beat after an optional idle gap; start stays high
	// on return so a back-to-back beat can follow without a glitch
	task automatic key_char(input logic [7:0] c, input int gap, output int nsegs);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (busy !== 1'b0);
		nsegs = key_char_segments(c);
		chars_sent++;
		if (nsegs == 0)
			chars_silent++;
	endtask

	task automatic key_text(input string s);
		int n;
		for (int i = 0; i < s.len(); i++)
			key_char(s[i], pick_gap(), n);
	endtask

	// Hold off until every queued segment has been seen and the unit settles
	task automatic drain_segments();
		start <= 1'b0;
		while (pending_segs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_unit(input logic [15:0] ticks);
		drain_segments();
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		unit_ticks = ticks;
		unit_writes++;
	endtask

	// Compare each segment beat with the oldest expectation
	always @(posedge clk) begin : seg_check
		segment_t want;
		if (arst_n && strobe === 1'b1) begin
			if (pending_segs.size() == 0) begin
				$error("unexpected segment: key_on=%0b duration_ticks=%0d last=%0b",
					key_on, duration_ticks, last);
				failures++;
			end else begin
				want = pending_segs.pop_front();
				segs_checked++;
				if (key_on !== want.key) begin
					$error("key_on: expected %0b, got %0b", want.key, key_on);
					failures++;
				end
				if (duration_ticks !== want.dur) begin
					$error("duration_ticks: expected %0d, got %0d", want.dur, duration_ticks);
					failures++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					failures++;
				end
				if (want.dur > longest_seg)
					longest_seg = want.dur;
			end
		end
	end

	// Unit length straight out of reset
	task automatic test_reset_unit();
		key_text("E S");
	endtask

	// Both cases, digits, spaces and a spread of characters with no code
	task automatic test_char_classes();
		int n;
		key_text("aZ5Q  ");
		key_char(8'h00, 0, n);
		key_char(8'hFF, 0, n);
		key_char(8'h80, 1, n);
		key_text("@[`{/:");
		drain_segments();
	endtask

	// Shortest, longest and zero unit lengths
	task automatic test_unit_extremes();
		write_unit(16'd1);
		key_text("0T ");
		write_unit(16'hFFFF);
		key_text("0 ");
		write_unit(16'd0);
		key_text("K ");
	endtask

	// Random text across several unit settings, some runs without idling
	task automatic test_random_text();
		int keyed;
		int n;
		int phase;
		bit burst;
		keyed = 0;
		phase = 0;
		while (keyed < RANDOM_CHARS) begin
			if (phase % 3 == 0)
				write_unit(16'($urandom_range(16, 1)));
			else
				write_unit(16'($urandom_range(65535, 1)));
			burst = ($urandom_range(2, 0) == 0);
			for (int i = 0; i < 50; i++) begin
				key_char(pick_char(), burst ? 0 : pick_gap(), n);
				if (n > 0)
					keyed++;
				if ($urandom_range(39, 0) == 0)
					drain_segments();
			end
			phase++;
		end
		write_unit(UNIT_RESET);
		key_text("SOS 73");
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_unit();
		test_char_classes();
		test_unit_extremes();
		test_random_text();
		drain_segments();
		repeat (10) @(posedge clk);
		$display("Keyed %0d characters (%0d without segments) over %0d unit settings",
			chars_sent, chars_silent, unit_writes);
		$display("Checked %0d segments, longest %0d ticks", segs_checked, longest_seg);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("run timed out with %0d segments outstanding", pending_segs.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ morse_code_keyer_unit.f @@
design/mck_pkg.sv
design/mck_seq.sv
design/mck_datapath.sv
design/morse_code_keyer_unit.sv
tb/tb_top.sv
